### sv/xcr_pkg.sv
`default_nettype none
package xcr_pkg;

   localparam int unsigned PAYLOAD_LEN = 128;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned CRC_W     = 16;
   localparam int unsigned CNT_W     = 32;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned VERDICT_W = 2;
   localparam int unsigned STATUS_W  = 3;

   localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

   localparam logic [BYTE_W-1:0] CH_SOH  = 8'h01;
   localparam logic [BYTE_W-1:0] CH_EOT  = 8'h04;
   localparam logic [BYTE_W-1:0] CH_ACK  = 8'h06;
   localparam logic [BYTE_W-1:0] CH_CAN  = 8'h18;
   localparam logic [BYTE_W-1:0] CH_POLL = 8'h43;

   localparam logic [CSR_IDX_W-1:0] CSR_POLL_INTERVAL = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTE_TIMEOUT  = 1'd1;

   localparam logic [CNT_W-1:0] POLL_INTERVAL_RST = 32'd500000;
   localparam logic [CNT_W-1:0] BYTE_TIMEOUT_RST  = 32'd10000000;

   localparam logic [VERDICT_W-1:0] VERDICT_NONE   = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_REJECT = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_ACTIVE    = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_EOT       = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_CANCELLED = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_PKT   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_TIMEOUT   = 3'd4;

   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   typedef struct packed {
      logic              req_type;
      logic [BYTE_W-1:0] rx_byte;
   } item_type;

   typedef struct packed {
      logic                 data_valid;
      logic [BYTE_W-1:0]    data_byte;
      logic                 data_last;
      logic                 tx_valid;
      logic [BYTE_W-1:0]    tx_byte;
      logic [VERDICT_W-1:0] packet_verdict;
      logic [STATUS_W-1:0]  session_status;
   } result_type;

endpackage
`default_nettype wire

### sv/xcr_ifs.sv
`default_nettype none
interface xcr_req_if;
   logic                       valid;
   logic                       ready;
   logic                       req_type;
   logic [xcr_pkg::BYTE_W-1:0] rx_byte;
   modport source(output valid, req_type, rx_byte, input ready);
   modport sink(input valid, req_type, rx_byte, output ready);
endinterface

interface xcr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          data_valid;
   logic [xcr_pkg::BYTE_W-1:0]    data_byte;
   logic                          data_last;
   logic                          tx_valid;
   logic [xcr_pkg::BYTE_W-1:0]    tx_byte;
   logic [xcr_pkg::VERDICT_W-1:0] packet_verdict;
   logic [xcr_pkg::STATUS_W-1:0]  session_status;
   modport source(output valid, data_valid, data_byte, data_last, tx_valid, tx_byte,
                  packet_verdict, session_status, input ready);
   modport sink(input valid, data_valid, data_byte, data_last, tx_valid, tx_byte,
                packet_verdict, session_status, output ready);
endinterface

interface xcr_csr_if;
   logic                          valid;
   logic                          ready;
   logic [xcr_pkg::CSR_IDX_W-1:0] index;
   logic [xcr_pkg::CNT_W-1:0]     data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

### sv/xcr_crc16.sv
`default_nettype none
module xcr_crc16 (
   input  wire logic [xcr_pkg::CRC_W-1:0]  crc_cur,
   input  wire logic [xcr_pkg::BYTE_W-1:0] data,
   output logic      [xcr_pkg::CRC_W-1:0]  crc_nxt
);

   always_comb begin
      logic [xcr_pkg::CRC_W-1:0] c;
      c = crc_cur ^ {data, {(xcr_pkg::CRC_W - xcr_pkg::BYTE_W){1'b0}}};
      for (int i = 0; i < xcr_pkg::BYTE_W; i++) begin
         if (c[xcr_pkg::CRC_W-1]) begin
            c = {c[xcr_pkg::CRC_W-2:0], 1'b0} ^ xcr_pkg::CRC_POLY;
         end else begin
            c = {c[xcr_pkg::CRC_W-2:0], 1'b0};
         end
      end
      crc_nxt = c;
   end

endmodule
`default_nettype wire

### sv/xcr_ctrl.sv
`default_nettype none
module xcr_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      step,
   input  wire xcr_pkg::item_type         item,
   input  wire logic [xcr_pkg::CNT_W-1:0] poll_interval,
   input  wire logic [xcr_pkg::CNT_W-1:0] byte_timeout,
   output logic                           res_vld,
   output xcr_pkg::result_type            res
);

   localparam logic [2:0] PH_WAIT = 3'd0;
   localparam logic [2:0] PH_LEAD = 3'd1;
   localparam logic [2:0] PH_SEQ1 = 3'd2;
   localparam logic [2:0] PH_SEQ2 = 3'd3;
   localparam logic [2:0] PH_DATA = 3'd4;
   localparam logic [2:0] PH_CRCH = 3'd5;
   localparam logic [2:0] PH_CRCL = 3'd6;
   localparam logic [2:0] PH_DONE = 3'd7;

   localparam int unsigned BW = xcr_pkg::BYTE_W;
   localparam int unsigned CW = xcr_pkg::CNT_W;
   localparam logic [BW:0] PAYLOAD_LEN_W = (BW+1)'(xcr_pkg::PAYLOAD_LEN);

   logic [2:0]                phase_ff, phase_in;
   logic [BW-1:0]             expected_seq_ff, expected_seq_in;
   logic [BW-1:0]             seq_first_ff, seq_first_in;
   logic [BW-1:0]             seq_second_ff, seq_second_in;
   logic [xcr_pkg::CRC_W-1:0] running_crc_ff, running_crc_in;
   logic [BW-1:0]             crc_high_ff, crc_high_in;
   logic [BW-1:0]             byte_count_ff, byte_count_in;
   logic [CW-1:0]             poll_counter_ff, poll_counter_in;
   logic [CW-1:0]             idle_counter_ff, idle_counter_in;

   logic [xcr_pkg::CRC_W-1:0] crc_nxt;
   logic                      is_tick;
   logic [BW-1:0]             rx;
   logic [2:0]                lead_phase;
   xcr_pkg::result_type       lead_res;
   logic                      lead_vld;
   logic [CW:0]               poll_sum;
   logic [CW-1:0]             idle_sum;
   logic [BW:0]               count_sum;
   logic                      pkt_ok;

   xcr_crc16 u_crc (
      .crc_cur (running_crc_ff),
      .data    (rx),
      .crc_nxt (crc_nxt)
   );

   assign is_tick   = (item.req_type == xcr_pkg::REQ_TICK);
   assign rx        = item.rx_byte;
   assign poll_sum  = {1'b0, poll_counter_ff} + (CW+1)'(1);
   assign idle_sum  = idle_counter_ff + CW'(1);
   assign count_sum = {1'b0, byte_count_ff} + (BW+1)'(1);
   assign pkt_ok    = ({crc_high_ff, rx} == running_crc_ff) &&
                      (seq_first_ff == expected_seq_ff) &&
                      (seq_second_ff == ~expected_seq_ff);

   // lead byte: SOH opens a packet, EOT ends cleanly, anything else cancels
   always_comb begin
      lead_res = '0;
      lead_vld = 1'b1;
      if (rx == xcr_pkg::CH_SOH) begin
         lead_phase = PH_SEQ1;
         lead_vld   = 1'b0;
      end else if (rx == xcr_pkg::CH_EOT) begin
         lead_phase              = PH_DONE;
         lead_res.tx_valid       = 1'b1;
         lead_res.tx_byte        = xcr_pkg::CH_ACK;
         lead_res.session_status = xcr_pkg::STATUS_EOT;
      end else begin
         lead_phase              = PH_DONE;
         lead_res.session_status = xcr_pkg::STATUS_CANCELLED;
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      expected_seq_in = expected_seq_ff;
      seq_first_in    = seq_first_ff;
      seq_second_in   = seq_second_ff;
      running_crc_in  = running_crc_ff;
      crc_high_in     = crc_high_ff;
      byte_count_in   = byte_count_ff;
      poll_counter_in = poll_counter_ff;
      idle_counter_in = idle_counter_ff;
      res_vld         = 1'b0;
      res             = '0;
      if (step && phase_ff != PH_DONE) begin
         if (phase_ff == PH_WAIT) begin
            if (is_tick) begin
               poll_counter_in = (poll_sum >= {1'b0, poll_interval}) ? '0 : poll_sum[CW-1:0];
               if (poll_counter_ff == '0) begin
                  res_vld      = 1'b1;
                  res.tx_valid = 1'b1;
                  res.tx_byte  = xcr_pkg::CH_POLL;
               end
            end else if (rx != '0) begin
               idle_counter_in = '0;
               phase_in        = lead_phase;
               res_vld         = lead_vld;
               res             = lead_res;
            end
         end else if (is_tick) begin
            idle_counter_in = idle_sum;
            if (idle_sum >= byte_timeout) begin
               phase_in           = PH_DONE;
               res_vld            = 1'b1;
               res.session_status = xcr_pkg::STATUS_TIMEOUT;
            end
         end else begin
            idle_counter_in = '0;
            unique case (phase_ff)
               PH_LEAD: begin
                  phase_in = lead_phase;
                  res_vld  = lead_vld;
                  res      = lead_res;
               end
               PH_SEQ1: begin
                  seq_first_in = rx;
                  phase_in     = PH_SEQ2;
               end
               PH_SEQ2: begin
                  seq_second_in  = rx;
                  running_crc_in = '0;
                  byte_count_in  = '0;
                  phase_in       = PH_DATA;
               end
               PH_DATA: begin
                  running_crc_in = crc_nxt;
                  byte_count_in  = count_sum[BW-1:0];
                  if (count_sum >= PAYLOAD_LEN_W) begin
                     phase_in      = PH_CRCH;
                     res.data_last = 1'b1;
                  end
                  res_vld        = 1'b1;
                  res.data_valid = 1'b1;
                  res.data_byte  = rx;
               end
               PH_CRCH: begin
                  crc_high_in = rx;
                  phase_in    = PH_CRCL;
               end
               default: begin
                  res_vld      = 1'b1;
                  res.tx_valid = 1'b1;
                  if (pkt_ok) begin
                     expected_seq_in    = expected_seq_ff + BW'(1);
                     phase_in           = PH_LEAD;
                     res.tx_byte        = xcr_pkg::CH_ACK;
                     res.packet_verdict = xcr_pkg::VERDICT_ACCEPT;
                  end else begin
                     phase_in           = PH_DONE;
                     res.tx_byte        = xcr_pkg::CH_CAN;
                     res.packet_verdict = xcr_pkg::VERDICT_REJECT;
                     res.session_status = xcr_pkg::STATUS_BAD_PKT;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_WAIT;
         expected_seq_ff <= BW'(1);
         seq_first_ff    <= '0;
         seq_second_ff   <= '0;
         running_crc_ff  <= '0;
         crc_high_ff     <= '0;
         byte_count_ff   <= '0;
         poll_counter_ff <= '0;
         idle_counter_ff <= '0;
      end else begin
         phase_ff        <= phase_in;
         expected_seq_ff <= expected_seq_in;
         seq_first_ff    <= seq_first_in;
         seq_second_ff   <= seq_second_in;
         running_crc_ff  <= running_crc_in;
         crc_high_ff     <= crc_high_in;
         byte_count_ff   <= byte_count_in;
         poll_counter_ff <= poll_counter_in;
         idle_counter_ff <= idle_counter_in;
      end
   end

   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DONE |-> !res_vld)
      else $error("item produced after session end");

   a_end_to_done: assert property (@(posedge clock) disable iff (reset)
      res_vld && res.session_status != xcr_pkg::STATUS_ACTIVE |=> phase_ff == PH_DONE)
      else $error("session end reported but phase not closed");

   a_seq_advance: assert property (@(posedge clock) disable iff (reset)
      res_vld && res.packet_verdict == xcr_pkg::VERDICT_ACCEPT
      |=> expected_seq_ff == $past(expected_seq_ff) + BW'(1))
      else $error("sequence not advanced on accepted packet");

   a_last_in_data: assert property (@(posedge clock) disable iff (reset)
      res_vld && res.data_last |-> res.data_valid && phase_ff == PH_DATA)
      else $error("last flag outside payload");

endmodule
`default_nettype wire

### sv/xmodem_crc_receiver_unit.sv
// XMODEM-CRC receiver. One item per clock while the result side is not stalled: a
// received byte or a time tick enters an input register, is worked by the state update
// (CRC-16 over one byte) and leaves through a one-deep result register; a result that
// waits on a stalled output holds the next item in the input register. Most items give
// no result. The user is to write registers poll_interval (index 0) and byte_timeout
// (index 1) only while idle; the block itself does not enforce this. The write port is
// always ready. Once a session ends the block stays silent until reset.
`default_nettype none
module xmodem_crc_receiver_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   xcr_req_if.sink    req_ch,
   xcr_rsp_if.source  rsp_ch,
   xcr_csr_if.sink    csr_ch
);

   logic                      in_vld_ff, in_vld_in;
   xcr_pkg::item_type         in_item_ff, in_item_in;
   logic                      out_vld_ff, out_vld_in;
   xcr_pkg::result_type       out_res_ff, out_res_in;
   logic [xcr_pkg::CNT_W-1:0] poll_interval_ff, poll_interval_in;
   logic [xcr_pkg::CNT_W-1:0] byte_timeout_ff, byte_timeout_in;

   logic                step;
   logic                req_take;
   logic                res_vld;
   xcr_pkg::result_type res;

   assign step     = in_vld_ff && (!out_vld_ff || rsp_ch.ready);
   assign req_take = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !in_vld_ff || step;
   assign csr_ch.ready = 1'b1;

   xcr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .item          (in_item_ff),
      .poll_interval (poll_interval_ff),
      .byte_timeout  (byte_timeout_ff),
      .res_vld       (res_vld),
      .res           (res)
   );

   always_comb begin
      in_vld_in  = in_vld_ff;
      in_item_in = in_item_ff;
      if (req_take) begin
         in_vld_in           = 1'b1;
         in_item_in.req_type = req_ch.req_type;
         in_item_in.rx_byte  = req_ch.rx_byte;
      end else if (step) begin
         in_vld_in = 1'b0;
      end

      out_vld_in = out_vld_ff;
      out_res_in = out_res_ff;
      if (step && res_vld) begin
         out_vld_in = 1'b1;
         out_res_in = res;
      end else if (rsp_ch.ready) begin
         out_vld_in = 1'b0;
      end

      poll_interval_in = poll_interval_ff;
      byte_timeout_in  = byte_timeout_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            xcr_pkg::CSR_POLL_INTERVAL: poll_interval_in = csr_ch.data;
            xcr_pkg::CSR_BYTE_TIMEOUT:  byte_timeout_in  = csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff        <= 1'b0;
         out_vld_ff       <= 1'b0;
         poll_interval_ff <= xcr_pkg::POLL_INTERVAL_RST;
         byte_timeout_ff  <= xcr_pkg::BYTE_TIMEOUT_RST;
      end else begin
         in_vld_ff        <= in_vld_in;
         out_vld_ff       <= out_vld_in;
         poll_interval_ff <= poll_interval_in;
         byte_timeout_ff  <= byte_timeout_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_ch.valid          = out_vld_ff;
   assign rsp_ch.data_valid     = out_res_ff.data_valid;
   assign rsp_ch.data_byte      = out_res_ff.data_byte;
   assign rsp_ch.data_last      = out_res_ff.data_last;
   assign rsp_ch.tx_valid       = out_res_ff.tx_valid;
   assign rsp_ch.tx_byte        = out_res_ff.tx_byte;
   assign rsp_ch.packet_verdict = out_res_ff.packet_verdict;
   assign rsp_ch.session_status = out_res_ff.session_status;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !rsp_ch.ready |-> !step)
      else $error("pending result overwritten");

   a_item_held: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !step |=> in_vld_ff && in_item_ff == $past(in_item_ff))
      else $error("unprocessed item lost");

   a_take_empty: assert property (@(posedge clock) disable iff (reset)
      req_take |-> !in_vld_ff || step)
      else $error("item taken into a full input register");

endmodule
`default_nettype wire

### tb/sv/xcr_checker.sv
package xcr_tb_pkg;

   function automatic logic [xcr_pkg::CRC_W-1:0] crc16_step(
      input logic [xcr_pkg::CRC_W-1:0]  crc,
      input logic [xcr_pkg::BYTE_W-1:0] value
   );
      logic [xcr_pkg::CRC_W-1:0] c;
      c = crc ^ {value, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ xcr_pkg::CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

module xcr_checker (
   input  logic clock,
   input  logic reset,
   xcr_req_if   req_ch,
   xcr_rsp_if   rsp_ch,
   xcr_csr_if   csr_ch,
   output int   fault_count,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import xcr_pkg::*;
   import xcr_tb_pkg::*;

   typedef enum logic [2:0] {
      PH_WAIT, PH_LEAD, PH_SEQ1, PH_SEQ2, PH_DATA, PH_CRCH, PH_CRCL, PH_DONE
   } phase_t;

   logic [CNT_W-1:0]  poll_interval;
   logic [CNT_W-1:0]  byte_timeout;
   logic [CNT_W-1:0]  poll_count;
   logic [CNT_W-1:0]  idle_count;
   phase_t            phase;
   logic [BYTE_W-1:0] want_seq;
   logic [BYTE_W-1:0] seq_a;
   logic [BYTE_W-1:0] seq_b;
   logic [BYTE_W-1:0] crc_high;
   logic [BYTE_W-1:0] data_count;
   logic [CRC_W-1:0]  crc_run;
   result_type        due_replies[$];
   int                faults = 0;
   int                due_count = 0;

   assign fault_count = faults;
   assign pending     = due_count;

   function automatic string show(input result_type r);
      return $sformatf("data %0d/%02h/%0d tx %0d/%02h verdict %0d status %0d",
                       r.data_valid, r.data_byte, r.data_last, r.tx_valid, r.tx_byte,
                       r.packet_verdict, r.session_status);
   endfunction

   function automatic void queue_reply(
      input logic                 dv,
      input logic [BYTE_W-1:0]    db,
      input logic                 dl,
      input logic                 tv,
      input logic [BYTE_W-1:0]    tb,
      input logic [VERDICT_W-1:0] verdict,
      input logic [STATUS_W-1:0]  status
   );
      due_replies.push_back({dv, db, dl, tv, tb, verdict, status});
   endfunction

   task automatic take_item(input item_type it);
      logic send;
      logic last;
      logic ok;
      if (phase == PH_DONE) return;
      if (phase == PH_WAIT && it.req_type == REQ_BYTE && it.rx_byte == '0) return;
      if (phase == PH_WAIT && it.req_type == REQ_TICK) begin
         send = poll_count == '0;
         poll_count = poll_count + 1'b1;
         if (poll_count >= poll_interval) poll_count = '0;
         if (send) queue_reply(1'b0, 8'h00, 1'b0, 1'b1, CH_POLL, VERDICT_NONE, STATUS_ACTIVE);
      end else if (it.req_type == REQ_TICK) begin
         idle_count = idle_count + 1'b1;
         if (idle_count >= byte_timeout) begin
            phase = PH_DONE;
            queue_reply(1'b0, 8'h00, 1'b0, 1'b0, 8'h00, VERDICT_NONE, STATUS_TIMEOUT);
         end
      end else begin
         idle_count = '0;
         case (phase)
            PH_WAIT, PH_LEAD: begin
               if (it.rx_byte == CH_SOH) begin
                  phase = PH_SEQ1;
               end else begin
                  phase = PH_DONE;
                  if (it.rx_byte == CH_EOT)
                     queue_reply(1'b0, 8'h00, 1'b0, 1'b1, CH_ACK, VERDICT_NONE, STATUS_EOT);
                  else
                     queue_reply(1'b0, 8'h00, 1'b0, 1'b0, 8'h00, VERDICT_NONE,
                                 STATUS_CANCELLED);
               end
            end
            PH_SEQ1: begin
               seq_a = it.rx_byte;
               phase = PH_SEQ2;
            end
            PH_SEQ2: begin
               seq_b      = it.rx_byte;
               crc_run    = '0;
               data_count = '0;
               phase      = PH_DATA;
            end
            PH_DATA: begin
               last       = (int'(data_count) + 1) >= PAYLOAD_LEN;
               crc_run    = crc16_step(crc_run, it.rx_byte);
               data_count = data_count + 1'b1;
               if (last) phase = PH_CRCH;
               queue_reply(1'b1, it.rx_byte, last, 1'b0, 8'h00, VERDICT_NONE, STATUS_ACTIVE);
            end
            PH_CRCH: begin
               crc_high = it.rx_byte;
               phase    = PH_CRCL;
            end
            default: begin
               ok = {crc_high, it.rx_byte} == crc_run && seq_a == want_seq &&
                    seq_b == ~want_seq;
               if (ok) begin
                  want_seq = want_seq + 1'b1;
                  phase    = PH_LEAD;
                  queue_reply(1'b0, 8'h00, 1'b0, 1'b1, CH_ACK, VERDICT_ACCEPT, STATUS_ACTIVE);
               end else begin
                  phase = PH_DONE;
                  queue_reply(1'b0, 8'h00, 1'b0, 1'b1, CH_CAN, VERDICT_REJECT, STATUS_BAD_PKT);
               end
            end
         endcase
      end
   endtask

   always @(posedge clock) begin
      item_type   it;
      result_type got;
      result_type want;
      if (reset) begin
         poll_interval = POLL_INTERVAL_RST;
         byte_timeout  = BYTE_TIMEOUT_RST;
         phase         = PH_WAIT;
         want_seq      = 8'd1;
         seq_a         = '0;
         seq_b         = '0;
         crc_run       = '0;
         crc_high      = '0;
         data_count    = '0;
         poll_count    = '0;
         idle_count    = '0;
         due_replies.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            if (csr_ch.index == CSR_POLL_INTERVAL) poll_interval = csr_ch.data;
            else if (csr_ch.index == CSR_BYTE_TIMEOUT) byte_timeout = csr_ch.data;
         end
         if (req_ch.valid && req_ch.ready) begin
            it.req_type = req_ch.req_type;
            it.rx_byte  = req_ch.rx_byte;
            take_item(it);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.data_valid, rsp_ch.data_byte, rsp_ch.data_last, rsp_ch.tx_valid,
                   rsp_ch.tx_byte, rsp_ch.packet_verdict, rsp_ch.session_status};
            if (due_replies.size() == 0) begin
               faults++;
               if (faults <= 10) $display("%0t: reply with none due: %s", $time, show(got));
            end else begin
               want = due_replies.pop_front();
               if (got.data_valid !== want.data_valid || got.data_byte !== want.data_byte ||
                   got.data_last !== want.data_last || got.tx_valid !== want.tx_valid ||
                   got.tx_byte !== want.tx_byte ||
                   got.packet_verdict !== want.packet_verdict ||
                   got.session_status !== want.session_status) begin
                  faults++;
                  if (faults <= 10)
                     $display("%0t: reply mismatch: expected %s, got %s",
                              $time, show(want), show(got));
               end
            end
         end
      end
      due_count <= due_replies.size();
   end

endmodule

### tb/sv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import xcr_pkg::*;

   localparam int LIMIT_CYCLES = 200000;

   logic              clock;
   logic              reset;
   int                fault_count;
   int                pending;
   int                cycle_count = 0;
   logic              steady = 1'b0;
   logic [CNT_W-1:0]  cur_timeout;
   logic [BYTE_W-1:0] next_seq;

   xcr_req_if req_ch ();
   xcr_rsp_if rsp_ch ();
   xcr_csr_if csr_ch ();

   xmodem_crc_receiver_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   xcr_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_ch      (csr_ch),
      .fault_count (fault_count),
      .pending     (pending)
   );

   function automatic logic [CRC_W-1:0] crc16_step(
      input logic [CRC_W-1:0]  crc,
      input logic [BYTE_W-1:0] value
   );
      logic [CRC_W-1:0] c;
      c = crc ^ {value, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   initial begin
      int hold;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         hold = steady ? 0 : $urandom_range(0, 4);
         if (hold != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   task automatic send_item(input logic kind, input logic [BYTE_W-1:0] value);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= kind;
      req_ch.rx_byte  <= value;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
   endtask

   // ticks before a byte stay below the timeout so the session lives on
   task automatic send_byte(input logic [BYTE_W-1:0] value);
      int cap;
      cap = (cur_timeout > 7) ? 6 : int'(cur_timeout) - 1;
      if (cap > 0 && $urandom_range(0, 11) == 0)
         repeat ($urandom_range(1, cap)) send_item(REQ_TICK, 8'($urandom));
      send_item(REQ_BYTE, value);
   endtask

   task automatic send_packet(
      input logic [BYTE_W-1:0] seq_first,
      input logic [BYTE_W-1:0] seq_second,
      input logic              spoil_crc,
      input int                data_bytes,
      input logic              edges
   );
      logic [CRC_W-1:0]  crc;
      logic [BYTE_W-1:0] value;
      crc = '0;
      send_byte(CH_SOH);
      send_byte(seq_first);
      send_byte(seq_second);
      for (int i = 0; i < data_bytes; i++) begin
         value = 8'($urandom);
         if (edges) begin
            case (i)
               0: value = 8'h00;
               1: value = 8'hFF;
               2: value = 8'h80;
               3: value = 8'h01;
               default: ;
            endcase
         end
         crc = crc16_step(crc, value);
         send_byte(value);
      end
      if (data_bytes == PAYLOAD_LEN) begin
         if (spoil_crc) crc ^= 16'(1 << $urandom_range(0, 15));
         send_byte(crc[15:8]);
         send_byte(crc[7:0]);
      end
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [CNT_W-1:0] value);
      drain();
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= value;
      do @(posedge clock); while (!(csr_ch.valid && csr_ch.ready));
      csr_ch.valid <= 1'b0;
      if (index == CSR_BYTE_TIMEOUT) cur_timeout = value;
   endtask

   initial begin
      int                kind;
      logic [BYTE_W-1:0] lead;
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.req_type <= REQ_BYTE;
      req_ch.rx_byte  <= '0;
      csr_ch.valid    <= 1'b0;
      csr_ch.index    <= CSR_POLL_INTERVAL;
      csr_ch.data     <= '0;
      cur_timeout = BYTE_TIMEOUT_RST;
      next_seq    = 8'd1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // waiting for the sender
      write_reg(CSR_POLL_INTERVAL, 32'd1);
      write_reg(CSR_BYTE_TIMEOUT, 32'd1);
      repeat (3) send_item(REQ_TICK, 8'hFF);
      send_item(REQ_BYTE, 8'h00);
      write_reg(CSR_POLL_INTERVAL, 32'd0);
      repeat (2) send_item(REQ_TICK, 8'h00);
      write_reg(CSR_POLL_INTERVAL, 32'hFFFF_FFFF);
      repeat (3) send_item(REQ_TICK, 8'h55);
      write_reg(CSR_POLL_INTERVAL, 32'd3);
      repeat (7) send_item(REQ_TICK, 8'hAA);

      for (int r = 0; r < 4; r++) begin
         steady = $urandom_range(0, 3) == 0;
         case ($urandom_range(0, 3))
            0: write_reg(CSR_POLL_INTERVAL, 32'd1);
            1: write_reg(CSR_POLL_INTERVAL, $urandom_range(2, 5));
            2: write_reg(CSR_POLL_INTERVAL, $urandom_range(6, 30));
            default: write_reg(CSR_POLL_INTERVAL, $urandom);
         endcase
         if ($urandom_range(0, 1) == 1) write_reg(CSR_BYTE_TIMEOUT, $urandom_range(0, 3));
         repeat ($urandom_range(15, 35)) begin
            if ($urandom_range(0, 4) == 0) send_item(REQ_BYTE, 8'h00);
            else send_item(REQ_TICK, 8'($urandom));
         end
      end

      // session of well-formed packets
      steady = 1'b0;
      write_reg(CSR_BYTE_TIMEOUT, 32'hFFFF_FFFF);
      send_packet(next_seq, ~next_seq, 1'b0, PAYLOAD_LEN, 1'b1);
      next_seq = next_seq + 1'b1;
      repeat (7) begin
         steady = $urandom_range(0, 3) == 0;
         case ($urandom_range(0, 5))
            0: write_reg(CSR_BYTE_TIMEOUT, 32'hFFFF_FFFF);
            1: write_reg(CSR_BYTE_TIMEOUT, $urandom_range(2, 8));
            2: write_reg(CSR_BYTE_TIMEOUT, $urandom_range(9, 1000));
            3: write_reg(CSR_POLL_INTERVAL, $urandom);
            default: ;
         endcase
         send_packet(next_seq, ~next_seq, 1'b0, PAYLOAD_LEN, 1'b0);
         next_seq = next_seq + 1'b1;
      end

      // one way out of the session
      steady = 1'b0;
      case ($urandom_range(0, 5))
         0: send_byte(CH_EOT);
         1: begin
            do lead = 8'($urandom); while (lead == CH_SOH || lead == CH_EOT);
            if ($urandom_range(0, 2) == 0) lead = 8'h00;
            send_byte(lead);
         end
         2: send_packet(next_seq, ~next_seq, 1'b1, PAYLOAD_LEN, 1'b0);
         3: begin
            if ($urandom_range(0, 1) == 1)
               send_packet(next_seq - 1'b1, ~(next_seq - 1'b1), 1'b0, PAYLOAD_LEN, 1'b0);
            else
               send_packet(next_seq, next_seq, 1'b0, PAYLOAD_LEN, 1'b0);
         end
         default: begin
            send_packet(next_seq, ~next_seq, 1'b0, $urandom_range(0, PAYLOAD_LEN), 1'b0);
            kind = $urandom_range(0, 2);
            write_reg(CSR_BYTE_TIMEOUT, kind);
            repeat (kind == 0 ? 1 : kind) send_item(REQ_TICK, 8'($urandom));
         end
      endcase

      // session over: all of this is ignored
      repeat (30) send_item(1'($urandom_range(0, 1)), 8'($urandom));
      drain();

      if (fault_count == 0 && pending == 0) $display("testbench: done, clean");
      else $display("testbench: done, errors");
      $finish;
   end

endmodule

### xmodem_crc_receiver_unit.f
sv/xcr_pkg.sv
sv/xcr_ifs.sv
sv/xcr_crc16.sv
sv/xcr_ctrl.sv
sv/xmodem_crc_receiver_unit.sv
tb/sv/xcr_checker.sv
tb/sv/testbench.sv
